// ----- src/assert_macros.svh -----
// Assertion macros used by the top level of the button debounce block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, silenced while rst_n is low.
`define BDLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define BDLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/bdlp_pkg.sv -----
// Types and constants of the button debounce and long-press block.
package bdlp_pkg;

  // Trigger mode codes.
  localparam logic [2:0] MODE_LOW    = 3'd0;
  localparam logic [2:0] MODE_HIGH   = 3'd1;
  localparam logic [2:0] MODE_RISE   = 3'd2;
  localparam logic [2:0] MODE_FALL   = 3'd3;
  localparam logic [2:0] MODE_CHANGE = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_EN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LONG    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL = 3'd5;

  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [2:0]  RST_TRIGGER_MODE = MODE_RISE;
  localparam logic [15:0] RST_DEBOUNCE_MS  = 16'd50;
  localparam logic [15:0] RST_LONG_MS      = 16'd1000;

  typedef struct packed {
    logic        level;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic short_event;
    logic long_event;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  trigger_mode;
    logic        long_press_enable;
    logic        block_long;
    logic [15:0] debounce_ms;
    logic [15:0] long_ms;
    logic        initial_level;
  } cfg_t;

endpackage

// ----- src/bdlp_cfg.sv -----
// Configuration register file of the button debounce block.
module bdlp_cfg
  import bdlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg,
  output logic                  ref_load
);

  cfg_t cfg_r, cfg_nxt;
  logic ref_load_r, ref_load_nxt;

  always_comb begin
    cfg_nxt      = cfg_r;
    ref_load_nxt = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_MODE:  cfg_nxt.trigger_mode      = cfg_wdata[2:0];
        REG_LONG_EN:       cfg_nxt.long_press_enable = cfg_wdata[0];
        REG_BLOCK_LONG:    cfg_nxt.block_long        = cfg_wdata[0];
        REG_DEBOUNCE_MS:   cfg_nxt.debounce_ms       = cfg_wdata[15:0];
        REG_LONG_MS:       cfg_nxt.long_ms           = cfg_wdata[15:0];
        REG_INITIAL_LEVEL: begin
          cfg_nxt.initial_level = cfg_wdata[0];
          ref_load_nxt          = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_mode      <= RST_TRIGGER_MODE;
      cfg_r.long_press_enable <= 1'b0;
      cfg_r.block_long        <= 1'b0;
      cfg_r.debounce_ms       <= RST_DEBOUNCE_MS;
      cfg_r.long_ms           <= RST_LONG_MS;
      cfg_r.initial_level     <= 1'b0;
      ref_load_r              <= 1'b0;
    end else begin
      cfg_r      <= cfg_nxt;
      ref_load_r <= ref_load_nxt;
    end
  end

  assign cfg      = cfg_r;
  assign ref_load = ref_load_r;

endmodule

// ----- src/bdlp_core.sv -----
// Press state and event decision for one button sample.
module bdlp_core
  import bdlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      ref_load,
  input  logic      proc_en,
  input  in_item_t  item,
  output out_item_t result
);

  logic [31:0] press_start_r, press_start_nxt;
  logic        held_r, held_nxt;
  logic        lock_r, lock_nxt;
  logic        first_r, first_nxt;
  logic        last_level_r, last_level_nxt;

  logic [31:0] elapsed;
  logic        deb_ok;
  logic        long_ok;
  logic        active;

  assign elapsed = item.now_ms - press_start_r;
  assign deb_ok  = elapsed >= {16'd0, cfg.debounce_ms};
  assign long_ok = elapsed >= {16'd0, cfg.long_ms};
  assign active  = (cfg.trigger_mode == MODE_RISE) ? item.level : ~item.level;

  always_comb begin
    press_start_nxt    = press_start_r;
    held_nxt           = held_r;
    lock_nxt           = lock_r;
    first_nxt          = first_r;
    last_level_nxt     = last_level_r;
    result.short_event = 1'b0;
    result.long_event  = 1'b0;

    case (cfg.trigger_mode)
      MODE_LOW:  result.short_event = ~item.level;
      MODE_HIGH: result.short_event = item.level;
      MODE_RISE, MODE_FALL: begin
        if (cfg.long_press_enable) begin
          if (active) begin
            held_nxt = 1'b1;
            if (deb_ok && !first_r && !cfg.block_long) begin
              first_nxt          = 1'b1;
              result.short_event = 1'b1;
            end
            if (long_ok && !(lock_r && cfg.block_long)) begin
              lock_nxt          = 1'b1;
              result.long_event = 1'b1;
            end
          end else begin
            result.short_event = deb_ok && !lock_r && held_r && cfg.block_long;
            held_nxt           = 1'b0;
            press_start_nxt    = item.now_ms;
            lock_nxt           = 1'b0;
            first_nxt          = 1'b0;
          end
        end else begin
          if (active) begin
            if (deb_ok && !lock_r) begin
              lock_nxt           = 1'b1;
              result.short_event = 1'b1;
            end
          end else begin
            press_start_nxt = item.now_ms;
            lock_nxt        = 1'b0;
          end
        end
      end
      MODE_CHANGE: begin
        if (item.level != last_level_r) begin
          if (deb_ok && !lock_r) begin
            lock_nxt           = 1'b1;
            result.short_event = 1'b1;
            last_level_nxt     = item.level;
          end
        end else begin
          press_start_nxt = item.now_ms;
          lock_nxt        = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_start_r <= '0;
      held_r        <= 1'b0;
      lock_r        <= 1'b0;
      first_r       <= 1'b0;
      last_level_r  <= 1'b0;
    end else if (ref_load) begin
      last_level_r <= cfg.initial_level;
    end else if (proc_en) begin
      press_start_r <= press_start_nxt;
      held_r        <= held_nxt;
      lock_r        <= lock_nxt;
      first_r       <= first_nxt;
      last_level_r  <= last_level_nxt;
    end
  end

endmodule

// ----- src/button_debounce_long_press.sv -----
// Top level of the button debounce and long-press detector.
//
// Each transfer on the input channel carries one sample of the button level
// and a free-running millisecond timestamp; each sample gives exactly one
// transfer on the result channel with a short-press and a long-press flag.
// A sample is held in the input register and is then decided: one 32-bit
// subtraction of the press start time from the timestamp, two compares
// against the debounce and long-press times, and the press state update,
// all landing in the result register at the same edge.
// The block takes one sample per clock cycle for as long as results are
// taken; a sample passes the input register and then the result register.
// Timestamps wrap modulo 2^32, so the elapsed time is correct across the wrap.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while no
// sample is in flight; writing the initial level also reloads the reference
// level used by change mode, through the registered ref_load strobe.
`include "assert_macros.svh"

module button_debounce_long_press
  import bdlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  logic      ref_load;

  // Input register stage.
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_data_r;

  // Result register stage.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t result;

  logic      in_take;
  logic      proc_en;

  // The held sample is decided whenever the result register is free or is
  // being emptied in this cycle; otherwise both stages stall.
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign proc_en  = s1_valid_r && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && in_stall);
  assign out_valid_nxt = proc_en || (out_valid_r && out_stall);

  bdlp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .ref_load  (ref_load)
  );

  bdlp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .ref_load (ref_load),
    .proc_en  (proc_en),
    .item     (s1_data_r),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers load without reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (proc_en) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A long-press flag only comes from rising or falling mode with long-press on.
  `BDLP_ASSERT(a_long_mode, out_valid_r && out_data_r.long_event |-> cfg.long_press_enable && (cfg.trigger_mode == MODE_RISE || cfg.trigger_mode == MODE_FALL), "long event outside long-press mode")

  // In long-press mode with block_long, the short flag fires on release and the long flag while held, so never both.
  `BDLP_ASSERT(a_block_excl, out_valid_r && cfg.block_long |-> !(out_data_r.short_event && out_data_r.long_event), "short and long event together under block_long")

  // A sample held back by a stalled result stays in the input register.
  `BDLP_ASSERT(a_s1_hold, s1_valid_r && in_stall |=> s1_valid_r && $stable(s1_data_r), "stalled sample lost")

  // Reset leaves both stages empty.
  `BDLP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid_r && !s1_valid_r, "pipeline not empty after reset")

endmodule
